// ===== design/memory_fit_allocator_macros.svh =====
// Assertion macros shared by the allocator's checking code.
`ifndef MEMORY_FIT_ALLOCATOR_MACROS_SVH
`define MEMORY_FIT_ALLOCATOR_MACROS_SVH

// Same-cycle implication, sampled on clk and held off while reset is low.
`define MFA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk and held off while reset is low.
`define MFA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/mfa_pkg.sv =====
// Shared types and constants of the memory fit allocator.
package mfa_pkg;

  // Placement policy codes held in the fit mode register.
  typedef enum logic [1:0] {
    FIT_FIRST = 2'd0,
    FIT_BEST  = 2'd1,
    FIT_WORST = 2'd2
  } fit_mode_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_SCAN = 2'd1,
    ST_WB   = 2'd2
  } state_t;

  // Operation codes carried on the input channel's tuser.
  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_REQUEST = 1'b1;

  // Register indexes, taken from address bit 2.
  localparam logic REG_FIT_MODE = 1'b0;
  localparam logic REG_BLOCKS   = 1'b1;

  // Field widths fixed by the interface.
  localparam int MODE_W   = 2;
  localparam int BLOCKS_W = 7;
  localparam int INDEX_W  = 6;
  localparam int AMOUNT_W = 16;

  localparam logic [BLOCKS_W-1:0] BLOCKS_RESET = 7'd64;

  // Control from the sequencer to the candidate picker.
  typedef struct packed {
    logic clear;  // start of a new request
    logic valid;  // a table entry is on the read data this cycle
  } pick_ctrl_t;

endpackage

// ===== design/mfa_picker.sv =====
// Candidate picker: tracks the chosen block over a scan of the size table.
module mfa_picker #(
  parameter int IDX_W     = 6,
  parameter int SIZE_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mfa_pkg::pick_ctrl_t  ctrl,
  input  logic [1:0]           mode,
  input  logic [SIZE_BITS-1:0] size,
  input  logic [IDX_W-1:0]     idx,
  input  logic [SIZE_BITS-1:0] amt,
  output logic                 found,
  output logic [IDX_W-1:0]     pick,
  output logic [SIZE_BITS-1:0] best
);

  logic                 found_r, found_nxt;
  logic [IDX_W-1:0]     pick_r;
  logic [SIZE_BITS-1:0] best_r;
  logic                 take;

  // Only blocks at least as large as the request compete. The first one always
  // wins; after that best fit wants strictly smaller and worst fit strictly
  // larger, so ties stay with the lower index.
  always_comb begin
    take = 1'b0;
    if (ctrl.valid && (size >= amt)) begin
      if (!found_r) begin
        take = 1'b1;
      end else begin
        case (mode)
          mfa_pkg::FIT_BEST:  take = (size < best_r);
          mfa_pkg::FIT_WORST: take = (size > best_r);
          default:            take = 1'b0;
        endcase
      end
    end
    found_nxt = ctrl.clear ? 1'b0 : (found_r | take);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else begin
      found_r <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      pick_r <= idx;
      best_r <= size;
    end
  end

  assign found = found_r;
  assign pick  = pick_r;
  assign best  = best_r;

endmodule

// ===== design/memory_fit_allocator.sv =====
// Top level of the memory fit allocator: size table, scan sequencer and ports.
// A load writes the table in its transfer and gives no result. A request reads the first
// L = min(blocks_in_use, MAX_BLOCKS) entries; its result is registered after the L reads, the
// last compare, a check that the read pipe is empty, and the write-back (straight to write-back at L = 0).
// One item at a time: the next is taken only after a request's write-back, later while a held
// result blocks the write-back. Reset (synchronous, active low) sets fit_mode 0, blocks_in_use 64; the table is not cleared.
module memory_fit_allocator #(
  parameter int MAX_BLOCKS = 64,
  parameter int SIZE_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst_n,

  // Input channel.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [5:0] entry_index, [21:6] amount, [23:22] zero
  input  logic        in_tuser,   // [0] op
  input  logic        in_tlast,   // last_request

  // Result channel.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [0] granted, [6:1] granted_index, [7] zero
  output logic        out_tlast,  // last_result

  // Configuration port.
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  `include "memory_fit_allocator_macros.svh"

  // Table index width and the width of a count that can hold MAX_BLOCKS itself.
  localparam int IDX_W = $clog2(MAX_BLOCKS);
  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam int CMP_W = (CNT_W > mfa_pkg::BLOCKS_W) ? CNT_W : mfa_pkg::BLOCKS_W;

  // ---------------------------------------------------------------------------
  // Configuration registers. pready is tied high, so every access completes in
  // its access phase. Address bit 2 selects the register; the low bits are the
  // byte offset within a word and are not decoded.
  // ---------------------------------------------------------------------------
  logic [mfa_pkg::MODE_W-1:0]   fit_mode_r;
  logic [mfa_pkg::BLOCKS_W-1:0] blocks_r;
  logic                         cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fit_mode_r <= mfa_pkg::FIT_FIRST;
      blocks_r   <= mfa_pkg::BLOCKS_RESET;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == mfa_pkg::REG_FIT_MODE) begin
        fit_mode_r <= cfg_pwdata[mfa_pkg::MODE_W-1:0];
      end else begin
        blocks_r <= cfg_pwdata[mfa_pkg::BLOCKS_W-1:0];
      end
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2] == mfa_pkg::REG_BLOCKS) begin
      cfg_prdata[mfa_pkg::BLOCKS_W-1:0] = blocks_r;
    end else begin
      cfg_prdata[mfa_pkg::MODE_W-1:0] = fit_mode_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Input field unpacking.
  // ---------------------------------------------------------------------------
  logic [mfa_pkg::INDEX_W-1:0]  in_index;
  logic [mfa_pkg::AMOUNT_W-1:0] in_amount;
  logic                         in_xfer;

  assign in_index  = in_tdata[5:0];
  assign in_amount = in_tdata[21:6];
  assign in_xfer   = in_tvalid & in_tready;

  // ---------------------------------------------------------------------------
  // Size table: one synchronous write port and one read port with a registered
  // read data. Loads write in their transfer cycle; a request's write-back of
  // the charged block happens in the write-back state. The two never overlap,
  // and reads only occur during the scan, so no forwarding is needed.
  // ---------------------------------------------------------------------------
  logic [SIZE_BITS-1:0] size_mem [MAX_BLOCKS];
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_addr;
  logic [SIZE_BITS-1:0] wr_data;
  logic                 rd_en;
  logic [IDX_W-1:0]     rd_addr;
  logic [SIZE_BITS-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      size_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= size_mem[rd_addr];
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer. A request latches its amount, its batch marker and the scan
  // length, then issues one read per cycle. The picker compares each read's data
  // in the cycle after its read. After the last compare the chosen block is charged
  // and the result is registered as soon as the output register is free.
  // ---------------------------------------------------------------------------
  mfa_pkg::state_t      state_r, state_nxt;
  logic [CNT_W-1:0]     rd_cnt_r, rd_cnt_nxt;
  logic [CNT_W-1:0]     limit_r, limit_nxt;
  logic [SIZE_BITS-1:0] amt_r, amt_nxt;
  logic                 last_r, last_nxt;
  logic                 pend_valid_r, pend_valid_nxt;
  logic [IDX_W-1:0]     pend_idx_r, pend_idx_nxt;
  logic [CMP_W-1:0]     blocks_cmp;
  logic [CMP_W-1:0]     max_cmp;
  logic                 load_in_range;
  logic                 out_free;
  logic                 out_load;

  mfa_pkg::pick_ctrl_t  pick_ctrl;
  logic                 found;
  logic [IDX_W-1:0]     pick;
  logic [SIZE_BITS-1:0] best;

  assign blocks_cmp    = CMP_W'(blocks_r);
  assign max_cmp       = CMP_W'(MAX_BLOCKS);
  assign load_in_range = (32'(in_index) < 32'(MAX_BLOCKS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= mfa_pkg::ST_IDLE;
      pend_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      pend_valid_r <= pend_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_cnt_r   <= rd_cnt_nxt;
    limit_r    <= limit_nxt;
    amt_r      <= amt_nxt;
    last_r     <= last_nxt;
    pend_idx_r <= pend_idx_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    rd_cnt_nxt     = rd_cnt_r;
    limit_nxt      = limit_r;
    amt_nxt        = amt_r;
    last_nxt       = last_r;
    pend_valid_nxt = 1'b0;
    pend_idx_nxt   = pend_idx_r;
    in_tready      = 1'b0;
    wr_en          = 1'b0;
    wr_addr        = pick;
    wr_data        = best - amt_r;
    rd_en          = 1'b0;
    rd_addr        = rd_cnt_r[IDX_W-1:0];
    pick_ctrl      = '0;
    out_load       = 1'b0;

    case (state_r)
      mfa_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_xfer) begin
          if (in_tuser == mfa_pkg::OP_LOAD) begin
            // A load beyond the table is dropped.
            wr_en   = load_in_range;
            wr_addr = IDX_W'(in_index);
            wr_data = SIZE_BITS'(in_amount);
          end else begin
            rd_cnt_nxt      = '0;
            limit_nxt       = (blocks_cmp > max_cmp) ? CNT_W'(MAX_BLOCKS)
                                                     : CNT_W'(blocks_cmp);
            amt_nxt         = SIZE_BITS'(in_amount);
            last_nxt        = in_tlast;
            pick_ctrl.clear = 1'b1;
            state_nxt       = mfa_pkg::ST_SCAN;
          end
        end
      end

      mfa_pkg::ST_SCAN: begin
        pick_ctrl.valid = pend_valid_r;
        if (rd_cnt_r < limit_r) begin
          rd_en          = 1'b1;
          rd_cnt_nxt     = CNT_W'(rd_cnt_r + 1'b1);
          pend_valid_nxt = 1'b1;
          pend_idx_nxt   = rd_cnt_r[IDX_W-1:0];
        end else if (!pend_valid_r) begin
          state_nxt = mfa_pkg::ST_WB;
        end
      end

      mfa_pkg::ST_WB: begin
        // Charge the block and publish the result together, once the output
        // register can take it.
        if (out_free) begin
          wr_en     = found;
          out_load  = 1'b1;
          state_nxt = mfa_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = mfa_pkg::ST_IDLE;
      end
    endcase
  end

  mfa_picker #(
    .IDX_W     (IDX_W),
    .SIZE_BITS (SIZE_BITS)
  ) u_picker (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (pick_ctrl),
    .mode  (fit_mode_r),
    .size  (rd_data_r),
    .idx   (pend_idx_r),
    .amt   (amt_r),
    .found (found),
    .pick  (pick),
    .best  (best)
  );

  // ---------------------------------------------------------------------------
  // Output register. It holds a finished result until its transfer, while the
  // input side is already free to take the next item.
  // ---------------------------------------------------------------------------
  logic                        out_valid_r, out_valid_nxt;
  logic                        out_granted_r;
  logic [mfa_pkg::INDEX_W-1:0] out_index_r;
  logic                        out_last_r;

  assign out_free = ~out_valid_r | out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_granted_r <= found;
      out_index_r   <= found ? mfa_pkg::INDEX_W'(pick) : '0;
      out_last_r    <= last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_index_r, out_granted_r};
  assign out_tlast  = out_last_r;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  `MFA_ASSERT_NOW(a_pick_in_scan, (state_r == mfa_pkg::ST_WB) && found,
    32'(pick) < 32'(limit_r), "chosen block lies outside the scanned range")
  `MFA_ASSERT_NOW(a_pick_fits, (state_r == mfa_pkg::ST_WB) && found,
    best >= amt_r, "chosen block is smaller than the request")
  `MFA_ASSERT_NOW(a_result_after_wb, $rose(out_tvalid),
    $past(state_r == mfa_pkg::ST_WB), "result appeared without a write-back")
  `MFA_ASSERT_NEXT(a_scan_ends,
    (state_r == mfa_pkg::ST_SCAN) && (rd_cnt_r >= limit_r) && !pend_valid_r,
    state_r == mfa_pkg::ST_WB, "scan did not end after its last compare")

endmodule
